/* hdl/gradient_magnitude_3d_stencil_assert.svh */
// Assertion helpers for the gradient magnitude stencil.
// Both expect i_clk and i_rst_n in scope.
`ifndef GRADIENT_MAGNITUDE_3D_STENCIL_ASSERT_SVH
`define GRADIENT_MAGNITUDE_3D_STENCIL_ASSERT_SVH

// Same-cycle implication.
`define GM3D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gm3d: same-cycle check failed");

// Next-cycle implication.
`define GM3D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gm3d: next-cycle check failed");

`endif

/* hdl/gm3d_pkg.sv */
package gm3d_pkg;

    localparam int DEF_MAX_X       = 64;
    localparam int DEF_MAX_Y       = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int MAX_Z           = 4096;

    localparam int ZW   = 12;   // plane counter
    localparam int SXW  = 7;    // size_x / size_y register
    localparam int SZW  = 13;   // size_z register
    localparam int SCW  = 16;   // step_scale register
    localparam int CFGW = 16;   // config write data
    localparam int STEPW = 6;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SIZE_X     = 2'd0;
    localparam t_cfg_idx CFG_SIZE_Y     = 2'd1;
    localparam t_cfg_idx CFG_SIZE_Z     = 2'd2;
    localparam t_cfg_idx CFG_STEP_SCALE = 2'd3;

    localparam logic [SXW-1:0] RST_SIZE_X     = 7'd64;
    localparam logic [SXW-1:0] RST_SIZE_Y     = 7'd64;
    localparam logic [SZW-1:0] RST_SIZE_Z     = 13'd64;
    localparam logic [SCW-1:0] RST_STEP_SCALE = 16'd128;

    // neighbour slots, read in this order
    localparam logic [2:0] NB_C  = 3'd0;
    localparam logic [2:0] NB_XP = 3'd1;
    localparam logic [2:0] NB_XM = 3'd2;
    localparam logic [2:0] NB_YP = 3'd3;
    localparam logic [2:0] NB_YM = 3'd4;
    localparam logic [2:0] NB_ZM = 3'd5;
    localparam int         NB_N  = 6;

    localparam logic [STEPW-1:0] READ_LAST = 6'd6;
    localparam logic [STEPW-1:0] SQR_LAST  = 6'd11;
    localparam logic [STEPW-1:0] ROOT_LAST = 6'd32;

    typedef struct packed {
        logic             store;      // take sample, write it now, no result
        logic             calc;       // take word that yields a result
        logic             calc_up;    // that word is a sample (z+1 neighbour)
        logic             rd;         // neighbour fetch
        logic             sqr;        // sum of squares
        logic             root_init;
        logic             root_step;
        logic             emit;       // load output register
        logic [STEPW-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic has_out;    // input plane above zero
        logic complete;   // last sample taken
        logic out_free;   // output register can take a word
    } t_stat;

endpackage

/* hdl/gm3d_dp.sv */
module gm3d_dp #(
    parameter int MAX_X       = 64,
    parameter int MAX_Y       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  gm3d_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [gm3d_pkg::CFGW-1:0]     i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_out_ready,
    input  gm3d_pkg::t_cmd                i_cmd,
    output gm3d_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [31:0]                   o_magnitude,
    output logic                          o_last
);
    import gm3d_pkg::*;

    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int AW    = 1 + XW + YW;
    localparam int DEPTH = 2 ** AW;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int PW    = SAMPLE_BITS + SCW;
    localparam int HW    = (PW + 1) / 2;
    localparam int SW    = 2 * PW + 2;
    localparam int QW    = SW - 16;
    localparam int QX    = (QW > 64) ? QW : 65;

    function automatic logic [AW-1:0] addr(input logic slot, input logic [YW-1:0] row,
                                           input logic [XW-1:0] col);
        return {slot, row, col};
    endfunction

    // configuration
    logic [SXW-1:0] r_size_x, r_size_y;
    logic [SZW-1:0] r_size_z;
    logic [SCW-1:0] r_scale;
    logic [XW:0]    sx;
    logic [YW:0]    sy;
    logic [SZW-1:0] sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= RST_SIZE_X;
            r_size_y <= RST_SIZE_Y;
            r_size_z <= RST_SIZE_Z;
            r_scale  <= RST_STEP_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X:     r_size_x <= i_cfg_data[SXW-1:0];
                CFG_SIZE_Y:     r_size_y <= i_cfg_data[SXW-1:0];
                CFG_SIZE_Z:     r_size_z <= i_cfg_data[SZW-1:0];
                CFG_STEP_SCALE: r_scale  <= i_cfg_data[SCW-1:0];
                default:        r_scale  <= r_scale;
            endcase
        end
    end

    always_comb begin
        if (r_size_x == '0)                sx = (XW+1)'(1);
        else if (32'(r_size_x) > MAX_X)    sx = (XW+1)'(MAX_X);
        else                               sx = (XW+1)'(r_size_x);
        if (r_size_y == '0)                sy = (YW+1)'(1);
        else if (32'(r_size_y) > MAX_Y)    sy = (YW+1)'(MAX_Y);
        else                               sy = (YW+1)'(r_size_y);
        if (r_size_z == '0)                sz = SZW'(1);
        else if (32'(r_size_z) > MAX_Z)    sz = SZW'(MAX_Z);
        else                               sz = r_size_z;
    end

    // stream position
    logic [XW-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [YW-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic [ZW-1:0] r_in_pl, r_out_pl, n_in_pl, n_out_pl;
    logic          r_complete, n_complete;
    logic          in_wrap, out_wrap;

    always_comb begin
        n_in_col = r_in_col + 1'b1;
        n_in_row = r_in_row;
        n_in_pl  = r_in_pl;
        in_wrap  = 1'b0;
        if (({1'b0, r_in_col} + 1'b1) >= sx) begin
            n_in_col = '0;
            n_in_row = r_in_row + 1'b1;
            if (({1'b0, r_in_row} + 1'b1) >= sy) begin
                n_in_row = '0;
                n_in_pl  = r_in_pl + 1'b1;
                if (({1'b0, r_in_pl} + 1'b1) >= sz) begin
                    n_in_pl = '0;
                    in_wrap = 1'b1;
                end
            end
        end
        n_out_col = r_out_col + 1'b1;
        n_out_row = r_out_row;
        n_out_pl  = r_out_pl;
        out_wrap  = 1'b0;
        if (({1'b0, r_out_col} + 1'b1) >= sx) begin
            n_out_col = '0;
            n_out_row = r_out_row + 1'b1;
            if (({1'b0, r_out_row} + 1'b1) >= sy) begin
                n_out_row = '0;
                n_out_pl  = r_out_pl + 1'b1;
                if (({1'b0, r_out_pl} + 1'b1) >= sz) begin
                    n_out_pl = '0;
                    out_wrap = 1'b1;
                end
            end
        end
        n_complete = r_complete | in_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_pl    <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_pl   <= '0;
            r_complete <= 1'b0;
        end else if (i_cmd.store || (i_cmd.calc && i_cmd.calc_up)) begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_pl    <= n_in_pl;
            r_complete <= n_complete;
            if (i_cmd.calc) begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_out_pl  <= n_out_pl;
            end
        end else if (i_cmd.calc) begin
            // drain: end of volume starts the next one
            if (out_wrap) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_pl    <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_pl   <= '0;
                r_complete <= 1'b0;
            end else begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_out_pl  <= n_out_pl;
            end
        end
    end

    // snapshot of the voxel being worked on
    logic [XW-1:0]                 r_x;
    logic [YW-1:0]                 r_y;
    logic [ZW-1:0]                 r_z;
    logic                          r_has_up, r_last_s;
    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic [AW-1:0]                 r_wa;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_x      <= r_out_col;
            r_y      <= r_out_row;
            r_z      <= r_out_pl;
            r_has_up <= i_cmd.calc_up;
            r_last_s <= !i_cmd.calc_up && out_wrap;
            r_samp   <= i_sample;
            r_wa     <= addr(r_in_pl[0], r_in_row, r_in_col);
        end
    end

    // plane store
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic signed [SAMPLE_BITS-1:0] r_nb [NB_N];
    logic                          we, re;
    logic [AW-1:0]                 wa, ra;
    logic signed [SAMPLE_BITS-1:0] wd;
    logic [XW-1:0]                 xp, xm;
    logic [YW-1:0]                 yp, ym;
    logic [2:0]                    cap_i;

    always_comb begin
        xp = (({1'b0, r_x} + 1'b1) < sx) ? r_x + 1'b1 : r_x;
        xm = (r_x != '0) ? r_x - 1'b1 : r_x;
        yp = (({1'b0, r_y} + 1'b1) < sy) ? r_y + 1'b1 : r_y;
        ym = (r_y != '0) ? r_y - 1'b1 : r_y;
        unique case (i_cmd.step[2:0])
            NB_XP:   ra = addr(r_z[0], r_y, xp);
            NB_XM:   ra = addr(r_z[0], r_y, xm);
            NB_YP:   ra = addr(r_z[0], yp, r_x);
            NB_YM:   ra = addr(r_z[0], ym, r_x);
            NB_ZM:   ra = addr(!r_z[0], r_y, r_x);
            default: ra = addr(r_z[0], r_y, r_x);
        endcase
        re    = i_cmd.rd && (i_cmd.step != READ_LAST);
        we    = i_cmd.store || (i_cmd.rd && (i_cmd.step == READ_LAST) && r_has_up);
        wa    = i_cmd.store ? addr(r_in_pl[0], r_in_row, r_in_col) : r_wa;
        wd    = i_cmd.store ? i_sample : r_samp;
        cap_i = i_cmd.step[2:0] - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (re) r_rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd && (i_cmd.step != '0)) r_nb[cap_i] <= r_rdata;
    end

    // sum of squares, one axis per four steps
    logic signed [DW-1:0]          diff;
    logic signed [SAMPLE_BITS-1:0] da, db, zp, zm;
    logic [SAMPLE_BITS-1:0]        mag_u;
    logic [PW-1:0]                 r_p;
    logic [HW-1:0]                 lo, hi, ma, mb;
    logic [2*HW-1:0]               pp;
    logic [SW-1:0]                 r_acc, term;

    always_comb begin
        zp = r_has_up ? r_samp : r_nb[NB_C];
        zm = (r_z != '0) ? r_nb[NB_ZM] : r_nb[NB_C];
        unique case (i_cmd.step[3:2])
            2'd0:    begin da = r_nb[NB_XP]; db = r_nb[NB_XM]; end
            2'd1:    begin da = r_nb[NB_YP]; db = r_nb[NB_YM]; end
            default: begin da = zp;          db = zm;          end
        endcase
        diff  = DW'(da) - DW'(db);
        mag_u = diff[DW-1] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
        lo    = r_p[HW-1:0];
        hi    = HW'(r_p[PW-1:HW]);
        ma    = (i_cmd.step[1:0] == 2'd3) ? hi : lo;
        mb    = (i_cmd.step[1:0] == 2'd1) ? lo : hi;
        pp    = (2*HW)'(ma) * (2*HW)'(mb);
        unique case (i_cmd.step[1:0])
            2'd1:    term = SW'(pp);
            2'd2:    term = SW'(pp) << (HW + 1);
            2'd3:    term = SW'(pp) << (2 * HW);
            default: term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_acc <= '0;
        end else if (i_cmd.sqr) begin
            if (i_cmd.step[1:0] == 2'd0) r_p <= PW'(mag_u) * PW'(r_scale);
            else                         r_acc <= r_acc + term;
        end
    end

    // square root, one result bit a step
    logic [QX-1:0] q;
    logic [63:0]   r_q;
    logic [33:0]   r_rem;
    logic [31:0]   r_root;
    logic          r_sat;
    logic [35:0]   rem_n, trial;

    always_comb begin
        q     = QX'(r_acc >> 16);
        rem_n = {r_rem, r_q[63:62]};
        trial = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_q    <= q[63:0];
            r_sat  <= |q[QX-1:64];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_q <= {r_q[61:0], 2'b00};
            if (rem_n >= trial) begin
                r_rem  <= 34'(rem_n - trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_n[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_magnitude <= r_sat ? '1 : r_root;
            o_last      <= r_last_s;
        end
    end

    assign o_stat.has_out  = (r_in_pl != '0);
    assign o_stat.complete = r_complete;
    assign o_stat.out_free = !o_out_valid || i_out_ready;

endmodule

/* hdl/gm3d_ctrl.sv */
module gm3d_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  gm3d_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output gm3d_pkg::t_cmd  o_cmd
);
    import gm3d_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [STEPW-1:0] r_step, n_step;
    logic             take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 1'b1;
        o_cmd   = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (take && !i_op && !i_stat.complete) begin
                    if (i_stat.has_out) begin
                        o_cmd.calc    = 1'b1;
                        o_cmd.calc_up = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end else if (take && i_op && i_stat.complete) begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (r_step == READ_LAST) begin
                    n_state = S_SQR;
                    n_step  = '0;
                end
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                if (r_step == SQR_LAST) begin
                    n_state = S_ROOT;
                    n_step  = '0;
                end
            end
            S_ROOT: begin
                o_cmd.root_init = (r_step == '0);
                o_cmd.root_step = (r_step != '0);
                if (r_step == ROOT_LAST) begin
                    n_state = S_EMIT;
                    n_step  = '0;
                end
            end
            S_EMIT: begin
                n_step     = '0;
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* hdl/gradient_magnitude_3d_stencil.sv */
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_ready    i_op, i_sample
// out       from block o_out_valid / i_out_ready  o_magnitude, o_last
// cfg       to block   i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// A sample that yields no result (first plane) is stored as it is taken.
// A word that yields a result holds the input until its result is in the output
// register: it is taken, the neighbours are fetched through the single read port
// of the plane store, the three squares are formed on one half-width multiplier,
// the bit-serial square root is run, and the controller waits for the output
// register to be free and loads it; the output register frees the input as soon
// as the result is loaded. Reset is synchronous and active low; the plane store
// needs no clearing, as each entry is written before read.
module gradient_magnitude_3d_stencil #(
    parameter int MAX_X       = gm3d_pkg::DEF_MAX_X,
    parameter int MAX_Y       = gm3d_pkg::DEF_MAX_Y,
    parameter int SAMPLE_BITS = gm3d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  gm3d_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [gm3d_pkg::CFGW-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_magnitude,
    output logic                          o_last
);
    import gm3d_pkg::*;

`include "gradient_magnitude_3d_stencil_assert.svh"

    t_cmd  cmd;
    t_stat stat;

    // sequence each word that yields a result: fetch, square, root, emit
    gm3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // plane store, position counters, arithmetic and output register
    gm3d_dp #(
        .MAX_X       (MAX_X),
        .MAX_Y       (MAX_Y),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_magnitude (o_magnitude),
        .o_last      (o_last)
    );

    // a first-plane sample is stored at once and leaves the block idle
    `GM3D_ASSERT_NEXT(a_store_stays_idle, cmd.store, o_in_ready)
    // a result only appears after the controller loads it
    `GM3D_ASSERT_IMP(a_out_from_emit, $rose(o_out_valid), $past(cmd.emit))
    // never store and compute on the same word
    `GM3D_ASSERT_IMP(a_one_kind, cmd.store || cmd.calc, !(cmd.store && cmd.calc))

endmodule
